// ===== design/pid_filtered_derivative_assert.svh =====
// Assertion macros for the PID controller with filtered derivative.
`ifndef PID_FILTERED_DERIVATIVE_ASSERT_SVH
`define PID_FILTERED_DERIVATIVE_ASSERT_SVH
`ifndef SYNTHESIS
`define PFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define PFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define PFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/pidfd_pkg.sv =====
// Shared types and constants of the PID controller with filtered derivative.
`default_nettype none
package pidfd_pkg;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS = 16;

	localparam logic [2:0] REG_KP = 3'd0;
	localparam logic [2:0] REG_KI = 3'd1;
	localparam logic [2:0] REG_KD = 3'd2;
	localparam logic [2:0] REG_IMAX = 3'd3;
	localparam logic [2:0] REG_TAU = 3'd4;

	typedef enum logic [1:0] {
		FUNC_PID = 2'd0,
		FUNC_PI  = 2'd1,
		FUNC_CLR = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DECODE, ST_ISSUE, ST_WAIT, ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		STEP_P, STEP_I1, STEP_I2, STEP_D1, STEP_D2, STEP_D3, STEP_D4
	} step_t;

	typedef enum logic {
		OP_MUL, OP_DIV
	} mdu_op_t;

	typedef struct packed {
		logic  load;
		logic  issue;
		logic  capture;
		logic  finish;
		step_t step;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  i_en;
		logic  d_en;
		logic  mdu_done;
		logic  out_free;
	} stat_t;
endpackage
`default_nettype wire

// ===== design/pidfd_regs.sv =====
// APB configuration registers: gains, integrator limit and filter time constant.
`default_nettype none
module pidfd_regs #(
	parameter int DATA_WIDTH = pidfd_pkg::DATA_WIDTH_DEF,
	parameter int PDW = (DATA_WIDTH - 1 > 32) ? 64 : 32,
	parameter int PAW = (DATA_WIDTH - 1 > 32) ? 6 : 5
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PAW-1:0]        paddr,
	input  wire logic [PDW-1:0]        pwdata,
	output logic      [PDW-1:0]        prdata,
	output logic                       pready,
	output logic      [DATA_WIDTH-2:0] kp,
	output logic      [DATA_WIDTH-2:0] ki,
	output logic      [DATA_WIDTH-2:0] kd,
	output logic      [DATA_WIDTH-2:0] imax,
	output logic      [DATA_WIDTH-2:0] tau
);
	import pidfd_pkg::*;

	localparam int SH = PAW - 3;

	logic [2:0] idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx = paddr[PAW-1:SH];
	assign wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp <= '0;
			ki <= '0;
			kd <= '0;
			imax <= '0;
			tau <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_KP: kp <= pwdata[DATA_WIDTH-2:0];
				REG_KI: ki <= pwdata[DATA_WIDTH-2:0];
				REG_KD: kd <= pwdata[DATA_WIDTH-2:0];
				REG_IMAX: imax <= pwdata[DATA_WIDTH-2:0];
				REG_TAU: tau <= pwdata[DATA_WIDTH-2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_KP: prdata = PDW'(kp);
			REG_KI: prdata = PDW'(ki);
			REG_KD: prdata = PDW'(kd);
			REG_IMAX: prdata = PDW'(imax);
			REG_TAU: prdata = PDW'(tau);
			default: prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== design/pidfd_mdu.sv =====
// Shared radix-2 multiply and restoring divide unit, one bit per cycle.
`default_nettype none
module pidfd_mdu #(
	parameter int OW = pidfd_pkg::DATA_WIDTH_DEF + pidfd_pkg::FRAC_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire pidfd_pkg::mdu_op_t op,
	input  wire logic [OW-1:0]      a,
	input  wire logic [OW-1:0]      b,
	output logic      [2*OW-1:0]    res,
	output logic                    done
);
	import pidfd_pkg::*;

	localparam int CW = $clog2(OW);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	mdu_op_t         op_q;
	logic [OW-1:0]   opnd_q;
	logic [2*OW-1:0] acc_q;
	logic [OW:0]     msum;
	logic [OW:0]     dsh;
	logic [OW:0]     ddif;
	logic            dbit;

	// multiply: add into upper half, shift right; divide: shift left, trial subtract
	assign msum = {1'b0, acc_q[2*OW-1:OW]} + (acc_q[0] ? {1'b0, opnd_q} : '0);
	assign dsh = {acc_q[2*OW-1:OW], acc_q[OW-1]};
	assign ddif = dsh - {1'b0, opnd_q};
	assign dbit = (dsh >= {1'b0, opnd_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				op_q <= op;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(OW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= {{OW{1'b0}}, (op == OP_MUL) ? b : a};
			opnd_q <= (op == OP_MUL) ? a : b;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				acc_q <= {msum, acc_q[OW-1:1]};
			end else begin
				acc_q <= {dbit ? ddif[OW-1:0] : dsh[OW-1:0], acc_q[OW-2:0], dbit};
			end
		end
	end

	assign res = acc_q;
	assign done = done_q;

	`include "pid_filtered_derivative_assert.svh"
	`PFD_ASSERT_NEXT(a_start_busy, clk, arst_n, start, busy_q, "unit not busy after start")
	`PFD_ASSERT_IMPL(a_done_idle, clk, arst_n, done_q, !busy_q && !start, "done while busy")
endmodule
`default_nettype wire

// ===== design/pidfd_dp.sv =====
// Datapath: operand selection, result truncation and saturation, loop state and output register.
`default_nettype none
module pidfd_dp #(
	parameter int DATA_WIDTH = pidfd_pkg::DATA_WIDTH_DEF,
	parameter int ITW = ((2 * DATA_WIDTH - 1 + 7) / 8) * 8,
	parameter int OTW = ((DATA_WIDTH + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [ITW-1:0]        s_tdata,
	input  wire logic [1:0]            s_tuser,
	output logic      [OTW-1:0]        m_tdata,
	output logic                       m_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [DATA_WIDTH-2:0] kp,
	input  wire logic [DATA_WIDTH-2:0] ki,
	input  wire logic [DATA_WIDTH-2:0] kd,
	input  wire logic [DATA_WIDTH-2:0] imax,
	input  wire logic [DATA_WIDTH-2:0] tau,
	input  wire pidfd_pkg::cmd_t       cmd,
	output pidfd_pkg::stat_t           stat
);
	import pidfd_pkg::*;

	localparam int W = DATA_WIDTH;
	localparam int OW = W + FRAC_BITS;
	localparam int PW = 2 * OW;

	func_t         func_q;
	logic [W-1:0]  err_q, p_q, i_q, d_q, t_q, raw_q;
	logic [W-2:0]  dt_q;
	logic [FRAC_BITS:0] alpha_q;
	logic          flag_q;
	logic [W-1:0]  isum_q, perr_q, prate_q;
	logic          m_tvalid_q;
	logic [W-1:0]  drive_q;
	logic          sat_q;

	logic [W:0]    diff_w, rd_w;
	logic          diff_f;
	logic [W-1:0]  diff_c;
	logic [W-1:0]  mag_err, mag_t, mag_diff, mag_rate;
	logic [W:0]    mag_rd;
	logic [OW-1:0] op_a, op_b;
	mdu_op_t       op_sel;
	logic          neg_c;
	logic [PW-1:0] res, src;
	logic          mdu_done;
	logic [W:0]    fmv;
	logic signed [W:0] acc, lim, acc_cl;
	logic signed [W+1:0] sum;
	logic          sum_ovf;
	logic [W-1:0]  drive_c;

	function automatic logic [W:0] fm(input logic [PW-1:0] mg, input logic neg);
		logic [PW-1:0] cap;
		logic [W-1:0]  v;
		logic          f;
		cap = neg ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
		f = (mg > cap);
		v = f ? cap[W-1:0] : mg[W-1:0];
		if (neg) v = -v;
		return {f, v};
	endfunction

	// error difference, saturated to the word
	assign diff_w = {err_q[W-1], err_q} - {perr_q[W-1], perr_q};
	assign diff_f = (diff_w[W] != diff_w[W-1]);
	assign diff_c = diff_f ? {diff_w[W], {(W-1){~diff_w[W]}}} : diff_w[W-1:0];
	assign rd_w = {raw_q[W-1], raw_q} - {prate_q[W-1], prate_q};

	assign mag_err = err_q[W-1] ? -err_q : err_q;
	assign mag_t = t_q[W-1] ? -t_q : t_q;
	assign mag_diff = diff_c[W-1] ? -diff_c : diff_c;
	assign mag_rate = prate_q[W-1] ? -prate_q : prate_q;
	assign mag_rd = rd_w[W] ? -rd_w : rd_w;

	always_comb begin
		op_a = '0;
		op_b = '0;
		op_sel = OP_MUL;
		neg_c = 1'b0;
		unique case (cmd.step)
			STEP_P: begin
				op_a = OW'(mag_err);
				op_b = OW'(kp);
				neg_c = err_q[W-1];
			end
			STEP_I1: begin
				op_a = OW'(mag_err);
				op_b = OW'(ki);
				neg_c = err_q[W-1];
			end
			STEP_I2: begin
				op_a = OW'(mag_t);
				op_b = OW'(dt_q);
				neg_c = t_q[W-1];
			end
			STEP_D1: begin
				op_a = {mag_diff, {FRAC_BITS{1'b0}}};
				op_b = OW'(dt_q);
				op_sel = OP_DIV;
				neg_c = diff_c[W-1];
			end
			STEP_D2: begin
				op_a = OW'({dt_q, {FRAC_BITS{1'b0}}});
				op_b = OW'({1'b0, tau} + {1'b0, dt_q});
				op_sel = OP_DIV;
			end
			STEP_D3: begin
				op_a = OW'(alpha_q);
				op_b = OW'(mag_rd);
				neg_c = rd_w[W];
			end
			STEP_D4: begin
				op_a = OW'(kd);
				op_b = OW'(mag_rate);
				neg_c = prate_q[W-1];
			end
			default: ;
		endcase
	end

	pidfd_mdu #(.OW(OW)) u_mdu (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.issue),
		.op(op_sel),
		.a(op_a),
		.b(op_b),
		.res(res),
		.done(mdu_done)
	);

	// quotients are taken whole, products drop the fraction bits
	assign src = (op_sel == OP_DIV) ? PW'(res[OW-1:0]) : (res >> FRAC_BITS);
	assign fmv = fm(src, neg_c);

	assign acc = (W+1)'($signed(fmv[W-1:0])) + (W+1)'($signed(isum_q));
	assign lim = $signed({2'b00, imax});
	always_comb begin
		acc_cl = acc;
		if (acc > lim) acc_cl = lim;
		if (acc < -lim) acc_cl = -lim;
	end

	assign sum = (W+2)'($signed(p_q)) + (W+2)'($signed(i_q)) + (W+2)'($signed(d_q));
	assign sum_ovf = !((sum[W+1:W-1] == 3'b000) || (sum[W+1:W-1] == 3'b111));
	assign drive_c = sum_ovf ? {sum[W+1], {(W-1){~sum[W+1]}}} : sum[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isum_q <= '0;
			perr_q <= '0;
			prate_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.finish) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			if (cmd.finish) begin
				if (func_q == FUNC_CLR) isum_q <= '0;
			end
			if (cmd.capture) begin
				if (cmd.step == STEP_I2) isum_q <= acc_cl[W-1:0];
				if (cmd.step == STEP_D3) begin
					prate_q <= prate_q + fmv[W-1:0];
					perr_q <= err_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q <= s_tdata[W-1:0];
			dt_q <= s_tdata[2*W-2:W];
			func_q <= func_t'(s_tuser);
			p_q <= '0;
			i_q <= '0;
			d_q <= '0;
			flag_q <= 1'b0;
		end
		if (cmd.capture) begin
			unique case (cmd.step)
				STEP_P: p_q <= fmv[W-1:0];
				STEP_I1: t_q <= fmv[W-1:0];
				STEP_I2: i_q <= acc_cl[W-1:0];
				STEP_D1: raw_q <= fmv[W-1:0];
				STEP_D2: alpha_q <= res[FRAC_BITS:0];
				STEP_D3: ;
				STEP_D4: d_q <= fmv[W-1:0];
				default: ;
			endcase
			if (cmd.step != STEP_D2) flag_q <= flag_q | fmv[W] | ((cmd.step == STEP_D1) & diff_f);
		end
		if (cmd.finish) begin
			drive_q <= drive_c;
			sat_q <= flag_q | sum_ovf;
		end
	end

	assign stat.func = func_q;
	assign stat.i_en = (ki != '0) && (dt_q != '0);
	assign stat.d_en = (func_q == FUNC_PID) && (kd != '0) && (dt_q != '0);
	assign stat.mdu_done = mdu_done;
	assign stat.out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = OTW'(drive_q);
	assign m_tuser = sat_q;
endmodule
`default_nettype wire

// ===== design/pidfd_ctrl.sv =====
// Controller: sequences the P, I and D steps over the shared arithmetic unit.
`default_nettype none
module pidfd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire pidfd_pkg::stat_t stat,
	output pidfd_pkg::cmd_t       cmd
);
	import pidfd_pkg::*;

	state_t state_q, state_n;
	step_t  step_q, step_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= STEP_P;
		end else begin
			state_q <= state_n;
			step_q <= step_n;
		end
	end

	always_comb begin
		state_n = state_q;
		step_n = step_q;
		s_tready = 1'b0;
		cmd = '{load: 1'b0, issue: 1'b0, capture: 1'b0, finish: 1'b0, step: step_q};
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_n = ST_DECODE;
				end
			end
			ST_DECODE: begin
				step_n = STEP_P;
				if (stat.func == FUNC_PID || stat.func == FUNC_PI) state_n = ST_ISSUE;
				else state_n = ST_FINISH;
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				state_n = ST_WAIT;
			end
			ST_WAIT: begin
				if (stat.mdu_done) begin
					cmd.capture = 1'b1;
					state_n = ST_ISSUE;
					unique case (step_q)
						STEP_P: begin
							if (stat.i_en) step_n = STEP_I1;
							else if (stat.d_en) step_n = STEP_D1;
							else state_n = ST_FINISH;
						end
						STEP_I1: step_n = STEP_I2;
						STEP_I2: begin
							if (stat.d_en) step_n = STEP_D1;
							else state_n = ST_FINISH;
						end
						STEP_D1: step_n = STEP_D2;
						STEP_D2: step_n = STEP_D3;
						STEP_D3: step_n = STEP_D4;
						STEP_D4: state_n = ST_FINISH;
						default: state_n = ST_FINISH;
					endcase
				end
			end
			ST_FINISH: begin
				// hold until the output register is free
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	`include "pid_filtered_derivative_assert.svh"
	`PFD_ASSERT_NEXT(a_issue_once, clk, arst_n, cmd.issue, !cmd.issue, "issue held two cycles")
	`PFD_ASSERT_IMPL(a_done_in_wait, clk, arst_n, stat.mdu_done, state_q == ST_WAIT, "done outside wait")
	`PFD_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready, "second transaction taken")
endmodule
`default_nettype wire

// ===== design/pid_filtered_derivative.sv =====
// From the accepting edge, the controller decodes the function and runs the P, I and D steps
// (PI skips the D steps, the reset op runs none), then registers the result and raises m_tvalid.
// Each multiply or divide runs as issue, busy in the shared unit, then capture.
// Throughput: one transaction at a time; the next is taken the cycle after the result is
// registered, even while that result still waits on the output side.
// Reset: arst_n clears registers, integrator and derivative state, and the controller.
`default_nettype none
module pid_filtered_derivative #(
	parameter int DATA_WIDTH = pidfd_pkg::DATA_WIDTH_DEF,
	parameter int ITW = ((2 * DATA_WIDTH - 1 + 7) / 8) * 8,
	parameter int OTW = ((DATA_WIDTH + 7) / 8) * 8,
	parameter int PDW = (DATA_WIDTH - 1 > 32) ? 64 : 32,
	parameter int PAW = (DATA_WIDTH - 1 > 32) ? 6 : 5
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic [ITW-1:0] s_tdata,  // error, dt, zero pad
	input  wire logic [1:0]     s_tuser,  // func
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic      [OTW-1:0] m_tdata,  // drive, zero pad
	output logic                m_tuser,  // saturated
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [PAW-1:0] paddr,
	input  wire logic [PDW-1:0] pwdata,
	output logic      [PDW-1:0] prdata,
	output logic                pready
);
	import pidfd_pkg::*;

	logic [DATA_WIDTH-2:0] kp, ki, kd, imax, tau;
	cmd_t  cmd;
	stat_t stat;

	pidfd_regs #(.DATA_WIDTH(DATA_WIDTH), .PDW(PDW), .PAW(PAW)) u_regs (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.kp(kp), .ki(ki), .kd(kd), .imax(imax), .tau(tau)
	);

	pidfd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.stat(stat), .cmd(cmd)
	);

	pidfd_dp #(.DATA_WIDTH(DATA_WIDTH), .ITW(ITW), .OTW(OTW)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.kp(kp), .ki(ki), .kd(kd), .imax(imax), .tau(tau),
		.cmd(cmd), .stat(stat)
	);
endmodule
`default_nettype wire
